>>> rtl/core/fcci_pkg.sv
// Shared constants, codes and types of the flash cartridge command interface.
package fcci_pkg;

  localparam int unsigned FLASH_AW_MAX = 20;
  localparam int unsigned FLASH_AW_DEF = 20;
  localparam int unsigned ERASE_AW_DEF = 16;

  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_PRELOAD = 2'd2;

  localparam logic [7:0] CMD_RESET        = 8'h00;
  localparam logic [7:0] CMD_READ_ARRAY   = 8'hFF;
  localparam logic [7:0] CMD_PROGRAM_A    = 8'h10;
  localparam logic [7:0] CMD_PROGRAM_B    = 8'h40;
  localparam logic [7:0] CMD_CLEAR_STATUS = 8'h50;
  localparam logic [7:0] CMD_READ_STATUS  = 8'h70;
  localparam logic [7:0] CMD_PAGE_STATUS  = 8'h71;
  localparam logic [7:0] CMD_VENDOR_READ  = 8'h75;
  localparam logic [7:0] CMD_CONFIRM      = 8'hD0;

  localparam logic [15:0] SEQ_BLOCK_ERASE = 16'h20D0;
  localparam logic [15:0] SEQ_CHIP_ERASE  = 16'hA7D0;

  localparam logic [3:0] BANK_REMAP  = 4'd14;
  localparam logic [3:0] BANK_MODE   = 4'd2;
  localparam logic [3:0] CTRL_WINDOW = 4'h5;

  localparam logic [7:0] RD_PAGE_STATUS   = 8'hC0;
  localparam logic [7:0] RD_GLOBAL_STATUS = 8'h82;
  localparam logic [7:0] RD_COMPAT_STATUS = 8'h80;
  localparam logic [7:0] RD_VENDOR_0      = 8'h4D;
  localparam logic [7:0] RD_VENDOR_2      = 8'h50;
  localparam logic [7:0] RD_VENDOR_6      = 8'h1A;
  localparam logic [7:0] VENDOR_LAST      = 8'h12;
  localparam logic [7:0] ERASED_BYTE      = 8'hFF;

  typedef struct packed {
    logic                    rd_en;
    logic [FLASH_AW_MAX-1:0] rd_addr;
    logic                    wr_en;
    logic [FLASH_AW_MAX-1:0] wr_addr;
    logic [7:0]              wr_data;
    logic                    erase_start;
    logic                    erase_chip;
    logic [FLASH_AW_MAX-1:0] erase_base;
  } fcci_mem_req_t;

endpackage

>>> rtl/core/fcci_in_if.sv
// Input channel carrying one bus access per beat.
interface fcci_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [23:0] bus_address;
  logic [7:0]  write_data;

  modport source (output valid, output operation, output bus_address, output write_data,
                  input ready);
  modport sink (input valid, input operation, input bus_address, input write_data,
                output ready);
endinterface

>>> rtl/core/fcci_out_if.sv
// Result channel carrying the read byte and the remap pulse per beat.
interface fcci_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       remap_request;

  modport source (output valid, output read_data, output remap_request, input ready);
  modport sink (input valid, input read_data, input remap_request, output ready);
endinterface

>>> rtl/core/flash_cart_command_interface_top.sv
// Top level of the flash cartridge command interface.
// The block takes one bus access per input beat on in_bus (read, write or preload of a flash
// byte) and returns exactly one result beat on out_bus: the byte read, or zero for writes
// and preloads, together with the remap pulse raised by a committing bank-14 write.
// In an ordinary access the beat is accepted and the flash read is issued in S_IDLE, and
// the result is formed and registered in S_EXEC once the result register is free; no new
// access is accepted until that result has been registered. The registered read port of
// the flash sets this.
// Block erase (0x20 then 0xD0) sweeps 2**ERASE_AW bytes and chip erase (0xA7 then 0xD0)
// sweeps 2**FLASH_AW bytes, one byte per cycle; the result beat of the confirming write is
// still delivered at once, but no new access is accepted until the sweep has ended.
// Reset clears the bank-control bytes, the dirty and mode bits, the command shift register
// and all status flags; the flash contents are left as they were and are undefined until
// preloaded. There is no clearing pass after reset.
// The result register holds a beat while out_bus.ready is low; an access already accepted
// waits with its flash data held until the register is free.
module flash_cart_command_interface_top #(
  parameter int unsigned FLASH_AW = fcci_pkg::FLASH_AW_DEF,
  parameter int unsigned ERASE_AW = fcci_pkg::ERASE_AW_DEF
) (
  input logic       clk,
  input logic       rst_n,
  fcci_in_if.sink   in_bus,
  fcci_out_if.source out_bus
);
  import fcci_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_ERASE = 3'b100
  } fcci_state_t;

  fcci_state_t state_r, state_nxt;

  logic [1:0]              op_r;
  logic [23:0]             addr_r;
  logic [7:0]              wdata_r;
  logic [FLASH_AW_MAX-1:0] idx_r;

  logic [7:0]  bc_r [16];
  logic [7:0]  bc_nxt [16];
  logic        dirty_r, dirty_nxt;
  logic        hirom_r, hirom_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic        page_r, page_nxt;
  logic        compat_r, compat_nxt;
  logic        global_r, global_nxt;
  logic        vendor_r, vendor_nxt;
  logic        armed_r, armed_nxt;

  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_remap_r;

  fcci_mem_req_t mem_req;
  logic [7:0]    mem_rdata;
  logic          mem_busy;

  logic                    accept, out_free, commit;
  logic [7:0]              in_bank;
  logic                    in_ctrl, in_hirom;
  logic [FLASH_AW_MAX-1:0] in_idx;
  logic [7:0]              bank;
  logic [3:0]              sel;
  logic                    ctrl;
  logic [7:0]              bc2_new;
  logic [15:0]             cmd_cat;
  logic [15:0]             low16;
  logic [7:0]              rd_val;
  logic                    remap;

  assign in_bus.ready = (state_r == S_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;
  assign commit       = (state_r == S_EXEC) && out_free;

  // An accepted bank-14 write that will remap forms its flash index in the mode it commits.
  assign in_bank  = in_bus.bus_address[23:16];
  assign in_ctrl  = (in_bank >= 8'd1) && (in_bank <= 8'd14) &&
                    (in_bus.bus_address[15:12] == CTRL_WINDOW);
  assign in_hirom = (in_bus.operation == OP_WRITE && in_ctrl &&
                     in_bank[3:0] == BANK_REMAP && dirty_r) ? (bc_r[BANK_MODE] != 8'd0)
                                                            : hirom_r;
  assign in_idx   = in_hirom ? in_bus.bus_address[19:0]
                             : {in_bus.bus_address[20:16], in_bus.bus_address[14:0]};

  assign bank    = addr_r[23:16];
  assign sel     = addr_r[19:16];
  assign ctrl    = (bank >= 8'd1) && (bank <= 8'd14) && (addr_r[15:12] == CTRL_WINDOW);
  assign bc2_new = (ctrl && sel == BANK_MODE) ? wdata_r : bc_r[BANK_MODE];
  assign cmd_cat = {cmd_r[7:0], wdata_r};
  assign low16   = addr_r[15:0];

  always_comb begin
    bc_nxt     = bc_r;
    dirty_nxt  = dirty_r;
    hirom_nxt  = hirom_r;
    cmd_nxt    = cmd_r;
    page_nxt   = page_r;
    compat_nxt = compat_r;
    global_nxt = global_r;
    vendor_nxt = vendor_r;
    armed_nxt  = armed_r;
    rd_val     = 8'd0;
    remap      = 1'b0;

    mem_req             = '0;
    mem_req.rd_en       = accept;
    mem_req.rd_addr     = in_idx;
    mem_req.wr_addr     = idx_r;

    if (commit) begin
      unique case (op_r)
        OP_READ: begin
          priority if (ctrl) begin
            rd_val = bc_r[sel];
          end else if ((low16 == 16'h0002 || low16 == 16'h8002) && page_r) begin
            rd_val = RD_PAGE_STATUS;
          end else if ((low16 == 16'h0004 || low16 == 16'h8004) && global_r) begin
            rd_val = RD_GLOBAL_STATUS;
          end else if (low16[15:8] == 8'hFF && low16[7:0] <= VENDOR_LAST && !low16[0] &&
                       vendor_r) begin
            if (low16[7:0] == 8'h00) begin
              rd_val = RD_VENDOR_0;
            end else if (low16[7:0] == 8'h02) begin
              rd_val = RD_VENDOR_2;
            end else if (low16[7:0] == 8'h06) begin
              rd_val = RD_VENDOR_6;
            end else begin
              rd_val = 8'd0;
            end
          end else if (compat_r) begin
            rd_val     = RD_COMPAT_STATUS;
            compat_nxt = 1'b0;
          end else begin
            rd_val = mem_rdata;
          end
        end
        OP_WRITE: begin
          if (ctrl) begin
            if (sel == BANK_REMAP && dirty_r) begin
              hirom_nxt = (bc_r[BANK_MODE] != 8'd0);
              dirty_nxt = 1'b0;
              remap     = 1'b1;
            end else if (sel != BANK_REMAP && bc_r[sel] != wdata_r) begin
              dirty_nxt = 1'b1;
            end
            bc_nxt[sel] = wdata_r;
          end
          if (armed_r) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = mem_rdata & wdata_r;
            armed_nxt       = 1'b0;
          end else begin
            cmd_nxt = cmd_cat;
            unique case (wdata_r)
              CMD_RESET, CMD_READ_ARRAY: begin
                page_nxt   = 1'b0;
                compat_nxt = 1'b0;
                global_nxt = 1'b0;
                vendor_nxt = 1'b0;
                armed_nxt  = 1'b0;
              end
              CMD_PROGRAM_A, CMD_PROGRAM_B: begin
                page_nxt   = 1'b0;
                compat_nxt = 1'b1;
                global_nxt = 1'b0;
                vendor_nxt = 1'b0;
                armed_nxt  = 1'b1;
              end
              CMD_CLEAR_STATUS: begin
                page_nxt   = 1'b0;
                compat_nxt = 1'b0;
                global_nxt = 1'b0;
              end
              CMD_READ_STATUS: begin
                page_nxt   = 1'b0;
                compat_nxt = 1'b1;
                global_nxt = 1'b0;
                vendor_nxt = 1'b0;
                armed_nxt  = 1'b0;
              end
              CMD_PAGE_STATUS: begin
                page_nxt   = 1'b1;
                compat_nxt = 1'b0;
                global_nxt = 1'b1;
                vendor_nxt = 1'b0;
                armed_nxt  = 1'b0;
              end
              CMD_VENDOR_READ: begin
                compat_nxt = 1'b0;
                vendor_nxt = 1'b1;
              end
              CMD_CONFIRM: begin
                if (cmd_cat == SEQ_BLOCK_ERASE) begin
                  mem_req.erase_start = 1'b1;
                  mem_req.erase_base  = (bc2_new != 8'd0) ? {addr_r[19:16], 16'h0000}
                                                          : {addr_r[20:17], 16'h0000};
                end else if (cmd_cat == SEQ_CHIP_ERASE) begin
                  mem_req.erase_start = 1'b1;
                  mem_req.erase_chip  = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        OP_PRELOAD: begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = addr_r[FLASH_AW_MAX-1:0];
          mem_req.wr_data = wdata_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = mem_req.erase_start ? S_ERASE : S_IDLE;
        end
      end
      S_ERASE: begin
        if (!mem_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bc_r        <= '{default: 8'd0};
      dirty_r     <= 1'b0;
      hirom_r     <= 1'b0;
      cmd_r       <= 16'd0;
      page_r      <= 1'b0;
      compat_r    <= 1'b0;
      global_r    <= 1'b0;
      vendor_r    <= 1'b0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bc_r     <= bc_nxt;
      dirty_r  <= dirty_nxt;
      hirom_r  <= hirom_nxt;
      cmd_r    <= cmd_nxt;
      page_r   <= page_nxt;
      compat_r <= compat_nxt;
      global_r <= global_nxt;
      vendor_r <= vendor_nxt;
      armed_r  <= armed_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_bus.operation;
      addr_r  <= in_bus.bus_address;
      wdata_r <= in_bus.write_data;
      idx_r   <= in_idx;
    end
    if (commit) begin
      out_data_r  <= rd_val;
      out_remap_r <= remap;
    end
  end

  fcci_flash #(
    .FLASH_AW (FLASH_AW),
    .ERASE_AW (ERASE_AW)
  ) u_flash (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rdata),
    .busy    (mem_busy)
  );

  assign out_bus.valid         = out_valid_r;
  assign out_bus.read_data     = out_data_r;
  assign out_bus.remap_request = out_remap_r;

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> !in_bus.ready)
    else $error("input accepted during an erase sweep");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC && !out_valid_r || state_r == S_EXEC && out_valid_r)
    else $error("accepted beat did not move to execution");

  a_remap_is_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_remap_r |-> out_data_r == 8'd0)
    else $error("remap pulse carried read data");

  a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("executed access produced no result beat");

endmodule

>>> rtl/core/fcci_flash.sv
// Flash byte store with one read port, one write port and the erase sweep.
module fcci_flash #(
  parameter int unsigned FLASH_AW = fcci_pkg::FLASH_AW_DEF,
  parameter int unsigned ERASE_AW = fcci_pkg::ERASE_AW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fcci_pkg::fcci_mem_req_t req,
  output logic [7:0]            rd_data,
  output logic                  busy
);
  import fcci_pkg::*;

  localparam int unsigned FLASH_BYTES = 1 << FLASH_AW;
  localparam int unsigned ERASE_BYTES = 1 << ERASE_AW;
  localparam logic [FLASH_AW-1:0] BLOCK_LAST = FLASH_AW'(ERASE_BYTES - 1);

  logic [7:0] mem [FLASH_BYTES];

  logic                busy_r, busy_nxt;
  logic                chip_r, chip_nxt;
  logic [FLASH_AW-1:0] base_r, base_nxt;
  logic [FLASH_AW-1:0] cnt_r, cnt_nxt;
  logic [FLASH_AW-1:0] sweep_addr;
  logic                sweep_last;
  logic                we;
  logic [FLASH_AW-1:0] waddr;
  logic [7:0]          wdata;

  assign sweep_addr = chip_r ? cnt_r : base_r + cnt_r;
  assign sweep_last = chip_r ? (&cnt_r) : (cnt_r == BLOCK_LAST);

  always_comb begin
    busy_nxt = busy_r;
    chip_nxt = chip_r;
    base_nxt = base_r;
    cnt_nxt  = cnt_r;
    if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (sweep_last) begin
        busy_nxt = 1'b0;
      end
    end else if (req.erase_start) begin
      busy_nxt = 1'b1;
      chip_nxt = req.erase_chip;
      base_nxt = req.erase_base[FLASH_AW-1:0];
      cnt_nxt  = '0;
    end
  end

  always_comb begin
    if (busy_r) begin
      we    = 1'b1;
      waddr = sweep_addr;
      wdata = ERASED_BYTE;
    end else begin
      we    = req.wr_en;
      waddr = req.wr_addr[FLASH_AW-1:0];
      wdata = req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    chip_r <= chip_nxt;
    base_r <= base_nxt;
    cnt_r  <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[FLASH_AW-1:0]];
    end
  end

  assign busy = busy_r;

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.erase_start && !req.wr_en && !req.rd_en)
    else $error("flash access requested during an erase sweep");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && sweep_last |=> !busy_r)
    else $error("erase sweep did not stop after its last byte");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && req.erase_start |=> busy_r && cnt_r == '0)
    else $error("erase request did not start a sweep");

endmodule

>>> test/tb_flash_cart_command_interface_top.sv
// Self-checking testbench of the flash cartridge command interface, with its own access predictor.
module tb_flash_cart_command_interface_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fcci_pkg::*;

  localparam int unsigned FLASH_BYTES = 1 << FLASH_AW_DEF;
  localparam int unsigned ERASE_BYTES = 1 << ERASE_AW_DEF;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int TAIL_CYCLES = 20;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [7:0] CMD_BLOCK_ERASE = SEQ_BLOCK_ERASE[15:8];
  localparam logic [7:0] CMD_CHIP_ERASE = SEQ_CHIP_ERASE[15:8];
  localparam logic [7:0] CMD_HARMLESS = CMD_CONFIRM + 8'd1;

  typedef struct packed {
    logic [7:0] read_data;
    logic       remap_request;
  } cart_reply_t;

  class cart_bus_tracker;
    logic [7:0]  ctrl_bytes [16];
    bit          dirty;
    bit          hirom;
    logic [15:0] shift;
    bit          page_on;
    bit          compat_on;
    bit          global_on;
    bit          vendor_on;
    bit          armed;
    logic [7:0]  flash_img [FLASH_BYTES];
    cart_reply_t replies [$];
    int          faults;

    function new();
      foreach (ctrl_bytes[i]) ctrl_bytes[i] = 8'h00;
      dirty = 1'b0;
      hirom = 1'b0;
      shift = 16'h0000;
      set_modes(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      faults = 0;
    endfunction

    function void set_modes(bit ps, bit cs, bit gs, bit vr, bit pa);
      page_on = ps;
      compat_on = cs;
      global_on = gs;
      vendor_on = vr;
      armed = pa;
    endfunction

    function bit in_ctrl_window(logic [23:0] a);
      return a[23:16] != 8'd0 && a[23:16] <= {4'h0, BANK_REMAP} && a[15:12] == CTRL_WINDOW;
    endfunction

    function logic [19:0] flash_slot(logic [23:0] a);
      return hirom ? a[19:0] : {a[20:16], a[14:0]};
    endfunction

    function logic [7:0] fetch(logic [23:0] a);
      logic [15:0] off;
      off = a[15:0];
      if (in_ctrl_window(a)) return ctrl_bytes[a[19:16]];
      if ((off == 16'h0002 || off == 16'h8002) && page_on) return RD_PAGE_STATUS;
      if ((off == 16'h0004 || off == 16'h8004) && global_on) return RD_GLOBAL_STATUS;
      if (off[15:8] == 8'hFF && off[7:0] <= VENDOR_LAST && !off[0] && vendor_on) begin
        case (off[7:0])
          8'h00: return RD_VENDOR_0;
          8'h02: return RD_VENDOR_2;
          8'h06: return RD_VENDOR_6;
          default: return 8'h00;
        endcase
      end
      if (compat_on) begin
        compat_on = 1'b0;
        return RD_COMPAT_STATUS;
      end
      return flash_img[flash_slot(a)];
    endfunction

    function bit store(logic [23:0] a, logic [7:0] v);
      bit          remap;
      logic [3:0]  sel;
      logic [19:0] base;
      logic [19:0] slot;
      int          i;
      remap = 1'b0;
      sel = a[19:16];
      if (in_ctrl_window(a)) begin
        if (sel == BANK_REMAP && dirty) begin
          hirom = ctrl_bytes[BANK_MODE] != 8'h00;
          dirty = 1'b0;
          remap = 1'b1;
        end else if (sel != BANK_REMAP && ctrl_bytes[sel] != v) begin
          dirty = 1'b1;
        end
        ctrl_bytes[sel] = v;
      end
      if (armed) begin
        slot = flash_slot(a);
        flash_img[slot] = flash_img[slot] & v;
        armed = 1'b0;
        return remap;
      end
      shift = {shift[7:0], v};
      case (v)
        CMD_RESET, CMD_READ_ARRAY: set_modes(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        CMD_PROGRAM_A, CMD_PROGRAM_B: set_modes(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
        CMD_CLEAR_STATUS: begin
          page_on = 1'b0;
          compat_on = 1'b0;
          global_on = 1'b0;
        end
        CMD_READ_STATUS: set_modes(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        CMD_PAGE_STATUS: set_modes(1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        CMD_VENDOR_READ: begin
          compat_on = 1'b0;
          vendor_on = 1'b1;
        end
        CMD_CONFIRM: begin
          if (shift == SEQ_BLOCK_ERASE) begin
            base = (ctrl_bytes[BANK_MODE] != 8'h00) ? {a[19:16], 16'h0000} : {a[20:17], 16'h0000};
            for (i = 0; i < ERASE_BYTES; i++) flash_img[20'(base + i)] = ERASED_BYTE;
          end else if (shift == SEQ_CHIP_ERASE) begin
            foreach (flash_img[j]) flash_img[j] = ERASED_BYTE;
          end
        end
        default: ;
      endcase
      return remap;
    endfunction

    function void take_access(logic [1:0] op, logic [23:0] a, logic [7:0] v);
      cart_reply_t reply;
      reply.read_data = 8'h00;
      reply.remap_request = 1'b0;
      case (op)
        OP_READ: reply.read_data = fetch(a);
        OP_WRITE: reply.remap_request = store(a, v);
        OP_PRELOAD: flash_img[a[FLASH_AW_DEF-1:0]] = v;
        default: ;
      endcase
      replies.push_back(reply);
    endfunction

    function void match_response(logic [7:0] rd, logic remap);
      cart_reply_t want;
      if (replies.size() == 0) begin
        $error("result beat with no access outstanding: read_data %02h, remap_request %0b",
               rd, remap);
        faults++;
        return;
      end
      want = replies.pop_front();
      if (rd !== want.read_data) begin
        $error("read_data: expected %02h, actual %02h", want.read_data, rd);
        faults++;
      end
      if (remap !== want.remap_request) begin
        $error("remap_request: expected %0b, actual %0b", want.remap_request, remap);
        faults++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct = 34;
  int   recv_idle_pct = 64;
  int   items_sent = 0;
  int   block_erases_left = 2;

  cart_bus_tracker cart = new();

  fcci_in_if  in_bus ();
  fcci_out_if out_bus ();

  flash_cart_command_interface_top #(
    .FLASH_AW(FLASH_AW_DEF),
    .ERASE_AW(ERASE_AW_DEF)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [23:0] rnd24();
    return 24'($urandom);
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic [23:0] status_addr();
    logic [15:0] off;
    case ($urandom_range(5))
      0: off = {CTRL_WINDOW, 12'($urandom)};
      1: off = 16'h0002;
      2: off = 16'h8002;
      3: off = 16'h0004;
      4: off = 16'h8004;
      default: off = 16'hFF00 + 16'($urandom_range(8'h13));
    endcase
    return {rnd8(), off};
  endfunction

  task automatic send(input logic [1:0] op, input logic [23:0] addr, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.operation <= op;
    in_bus.bus_address <= addr;
    in_bus.write_data <= data;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    cart.take_access(op, addr, data);
    items_sent++;
  endtask

  // Keeps random traffic away from chip erase and rations block erases.
  task automatic cart_write(input logic [23:0] addr, input logic [7:0] data);
    logic [7:0] d;
    d = data;
    if (d == CMD_CONFIRM && !cart.armed) begin
      if (cart.shift[7:0] == CMD_CHIP_ERASE) begin
        d = CMD_HARMLESS;
      end else if (cart.shift[7:0] == CMD_BLOCK_ERASE) begin
        if (block_erases_left == 0) d = CMD_HARMLESS;
        else block_erases_left--;
      end
    end
    send(OP_WRITE, addr, d);
  endtask

  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (cart.replies.size() != 0);
  endtask

  task automatic random_episode();
    logic [23:0] a;
    logic [7:0]  bank;
    logic [7:0]  d;
    case ($urandom_range(12))
      0, 1: send(OP_PRELOAD, rnd24(), rnd8());
      2: send(OP_READ, rnd24(), rnd8());
      3: repeat ($urandom_range(1, 3)) send(OP_READ, status_addr(), rnd8());
      4: begin
        bank = ($urandom_range(9) == 0) ? rnd8() : 8'($urandom_range(1, 14));
        if (bank == {4'h0, BANK_MODE}) d = ($urandom_range(2) == 0) ? rnd8() : 8'($urandom_range(1));
        else d = rnd8();
        cart_write({bank, CTRL_WINDOW, 12'($urandom)}, d);
        if ($urandom_range(1) == 0) cart_write({4'h0, BANK_REMAP, CTRL_WINDOW, 12'($urandom)}, rnd8());
        send(OP_READ, {bank, CTRL_WINDOW, 12'($urandom)}, rnd8());
      end
      5: begin
        cart_write(rnd24(), ($urandom_range(1) == 0) ? CMD_PROGRAM_A : CMD_PROGRAM_B);
        a = rnd24();
        cart_write(a, rnd8());
        send(OP_READ, a, rnd8());
        send(OP_READ, a, rnd8());
      end
      6: begin
        cart_write(rnd24(), CMD_READ_STATUS);
        repeat ($urandom_range(1, 2)) send(OP_READ, rnd24(), rnd8());
      end
      7: begin
        cart_write(rnd24(), CMD_PAGE_STATUS);
        repeat ($urandom_range(2, 4)) send(OP_READ, status_addr(), rnd8());
      end
      8: begin
        cart_write(rnd24(), CMD_VENDOR_READ);
        repeat ($urandom_range(2, 4))
          send(OP_READ, {rnd8(), 8'hFF, 8'($urandom_range(8'h13))}, rnd8());
      end
      9: begin
        case ($urandom_range(2))
          0: d = CMD_CLEAR_STATUS;
          1: d = CMD_RESET;
          default: d = CMD_READ_ARRAY;
        endcase
        cart_write(rnd24(), d);
      end
      10: begin
        a = rnd24();
        cart_write(a, CMD_BLOCK_ERASE);
        cart_write(a, CMD_CONFIRM);
        send(OP_READ, a, rnd8());
      end
      11: cart_write(rnd24(), rnd8());
      default: send(OP_UNUSED, rnd24(), rnd8());
    endcase
  endtask

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready)
        cart.match_response(out_bus.read_data, out_bus.remap_request);
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("flash_cart_command_interface_top test failed");
    $finish;
  end

  initial begin
    int phase;
    int goal;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.operation = OP_READ;
    in_bus.bus_address = '0;
    in_bus.write_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send(OP_READ, 24'h0E5FFF, 8'h00);
    send(OP_WRITE, 24'h000000, CMD_CHIP_ERASE);
    send(OP_WRITE, 24'hFFFFFF, CMD_CONFIRM);
    send(OP_PRELOAD, 24'hFFFFFF, 8'h00);
    send(OP_PRELOAD, 24'h000000, 8'h5A);
    send(OP_READ, 24'h000000, 8'hFF);
    send(OP_WRITE, {8'h00, BANK_REMAP, CTRL_WINDOW, 12'h000}, 8'h00);
    send(OP_WRITE, {4'h0, BANK_MODE, CTRL_WINDOW, 12'h000}, 8'h01);
    send(OP_WRITE, {4'h0, BANK_REMAP, CTRL_WINDOW, 12'hFFF}, CMD_READ_ARRAY);
    send(OP_READ, 24'hFFFFFF, 8'h00);
    send(OP_WRITE, 24'h123456, CMD_PROGRAM_B);
    send(OP_READ, 24'h000100, 8'h00);
    send(OP_WRITE, 24'h000000, 8'h0F);
    send(OP_READ, 24'h000000, 8'h00);
    send(OP_WRITE, 24'h000000, CMD_PAGE_STATUS);
    send(OP_READ, 24'h808002, 8'h00);
    send(OP_READ, 24'h000004, 8'h00);
    send(OP_WRITE, 24'h000000, CMD_VENDOR_READ);
    send(OP_READ, 24'h00FF00, 8'h00);
    send(OP_READ, 24'h00FF06, 8'h00);
    send(OP_READ, 24'h00FF12, 8'h00);
    send(OP_WRITE, 24'h3A0000, CMD_BLOCK_ERASE);
    send(OP_WRITE, 24'h3A0000, CMD_CONFIRM);
    send(OP_WRITE, {4'h0, BANK_MODE, CTRL_WINDOW, 12'h000}, 8'h00);
    send(OP_WRITE, {4'h0, BANK_REMAP, CTRL_WINDOW, 12'h000}, CMD_CLEAR_STATUS);
    send(OP_WRITE, 24'h1E0000, CMD_BLOCK_ERASE);
    send(OP_WRITE, 24'h1E0000, CMD_CONFIRM);
    send(OP_UNUSED, 24'hABCDEF, 8'h55);
    wait_for_results();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) random_episode();
      wait_for_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (cart.faults == 0 && cart.replies.size() == 0) begin
      $display("flash_cart_command_interface_top test passed");
    end else begin
      $display("flash_cart_command_interface_top test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/fcci_pkg.sv
rtl/core/fcci_in_if.sv
rtl/core/fcci_out_if.sv
rtl/core/fcci_flash.sv
rtl/core/flash_cart_command_interface_top.sv
test/tb_flash_cart_command_interface_top.sv
